// ===== design/ptc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pausable countdown timer package
// Shared widths, codes and saturating time arithmetic.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int TIME_BITS = 48;
  localparam int LEN_BITS  = TIME_BITS - 1;

  typedef logic signed [TIME_BITS-1:0] time_t;
  typedef logic [TIME_BITS-1:0]        utime_t;
  typedef logic [LEN_BITS-1:0]         len_t;

  localparam time_t T_MAX = {1'b0, {(TIME_BITS-1){1'b1}}};
  localparam time_t T_MIN = {1'b1, {(TIME_BITS-1){1'b0}}};

  localparam len_t  RESET_LENGTH = len_t'(300000);
  localparam time_t ONE_MINUTE   = time_t'(60000);

  typedef enum logic [3:0] {
    OP_QUERY      = 4'd0,
    OP_START      = 4'd1,
    OP_PAUSE      = 4'd2,
    OP_EXPIRE     = 4'd3,
    OP_MISS       = 4'd4,
    OP_RESET      = 4'd5,
    OP_REBOOT     = 4'd6,
    OP_TIME_SET   = 4'd7,
    OP_SET_LENGTH = 4'd8,
    OP_SET_REMAIN = 4'd9,
    OP_ADD_MINUTE = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    MODE_RUNNING = 3'd0,
    MODE_PAUSED  = 3'd1,
    MODE_EXPIRED = 3'd2,
    MODE_RESET   = 3'd3,
    MODE_MISSED  = 3'd4
  } mode_t;

  typedef enum logic {
    CFG_INITIAL_LENGTH = 1'b0,
    CFG_MIN_LENGTH     = 1'b1
  } cfg_index_t;

  function automatic time_t sat_add(time_t a, time_t b);
    logic signed [TIME_BITS:0] s;
    s = {a[TIME_BITS-1], a} + {b[TIME_BITS-1], b};
    if (s[TIME_BITS] != s[TIME_BITS-1]) begin
      sat_add = s[TIME_BITS] ? T_MIN : T_MAX;
    end else begin
      sat_add = s[TIME_BITS-1:0];
    end
  endfunction

  function automatic time_t sat_sub(time_t a, time_t b);
    logic signed [TIME_BITS:0] s;
    s = {a[TIME_BITS-1], a} - {b[TIME_BITS-1], b};
    if (s[TIME_BITS] != s[TIME_BITS-1]) begin
      sat_sub = s[TIME_BITS] ? T_MIN : T_MAX;
    end else begin
      sat_sub = s[TIME_BITS-1:0];
    end
  endfunction

  function automatic time_t clamp_zero(time_t a);
    clamp_zero = a[TIME_BITS-1] ? '0 : a;
  endfunction

  function automatic time_t clamp_input(utime_t v);
    clamp_input = v[TIME_BITS-1] ? T_MAX : time_t'(v);
  endfunction

endpackage

// ===== design/ptc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pausable countdown timer channels
// Command request channel and status request channel, valid/ready.
// ----------------------------------------------------------------------------
interface ptc_cmd_if;
  logic                   valid;
  logic                   ready;
  logic [3:0]             op;
  ptc_pkg::utime_t        now_ms;
  ptc_pkg::utime_t        wall_ms;
  ptc_pkg::time_t         arg_ms;

  modport source (output valid, output op, output now_ms, output wall_ms, output arg_ms,
                  input ready);
  modport sink   (input valid, input op, input now_ms, input wall_ms, input arg_ms,
                  output ready);
endinterface

interface ptc_status_if;
  logic                   valid;
  logic                   ready;
  logic [2:0]             timer_state;
  ptc_pkg::time_t         remaining_ms;
  ptc_pkg::time_t         total_ms;
  logic                   expiry_valid;
  ptc_pkg::time_t         expiry_at_ms;
  ptc_pkg::time_t         wall_expiry_at_ms;

  modport source (output valid, output timer_state, output remaining_ms, output total_ms,
                  output expiry_valid, output expiry_at_ms, output wall_expiry_at_ms,
                  input ready);
  modport sink   (input valid, input timer_state, input remaining_ms, input total_ms,
                  input expiry_valid, input expiry_at_ms, input wall_expiry_at_ms,
                  output ready);
endinterface

// ===== design/pausable_countdown_timer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pausable countdown timer core
// One timer record driven by command requests; one status request per command.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command request (opcode, monotonic time, wall time,
//   argument); status returns one status request for every command, in
//   order, showing the record after the command took effect.
//   The configuration port writes the initial length (which also reloads
//   the record into the reset state) and the minimum length; write it only
//   while no command is in flight.
//   Pipeline: a command is held in the input register, updates the record
//   as it passes into the update stage, and its status is then registered
//   in the status register, from which it can be taken.
//   Throughput: one command per cycle unless status stalls; the state update
//   per command is a single pass of saturating adders on the registered record.
//   Reset loads the record with a length of 300000 ms in the reset state,
//   clears the minimum length and empties the pipeline.
//   When status is stalled the status register holds; the two stages in
//   front keep filling, and cmd.ready drops only once all three are full.
// ----------------------------------------------------------------------------
module pausable_countdown_timer_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_index,
  input  ptc_pkg::len_t        cfg_wdata,
  ptc_cmd_if.sink              cmd,
  ptc_status_if.source         status
);

  // pipeline control
  logic out_en, s2_en, s1_en;
  logic s1_valid, s2_valid, out_valid;

  // input register
  ptc_pkg::op_t   s1_op;
  ptc_pkg::time_t s1_now, s1_wall, s1_arg;

  // update stage
  ptc_pkg::time_t s2_now;

  // timer record
  ptc_pkg::mode_t mode, mode_next;
  ptc_pkg::time_t set_length, set_length_next;
  ptc_pkg::time_t total_length, total_length_next;
  ptc_pkg::time_t stored_remaining, stored_remaining_next;
  ptc_pkg::time_t start_mono, start_mono_next;
  ptc_pkg::time_t start_wall, start_wall_next;
  ptc_pkg::len_t  len_floor;

  // status register
  logic [2:0]     out_state;
  ptc_pkg::time_t out_remaining, out_total, out_expiry, out_wall_expiry;
  logic           out_expiry_valid;

  logic           is_done, has_expiry;
  ptc_pkg::time_t run_remaining, boot_remaining, set_delta, tset_remaining;
  ptc_pkg::time_t new_remaining, new_total;
  logic           arg_above_min;
  logic           rem_change;

  ptc_pkg::time_t now_remaining;
  ptc_pkg::time_t load_len;

  assign out_en    = !out_valid || status.ready;
  assign s2_en     = !s2_valid || out_en;
  assign s1_en     = !s1_valid || s2_en;
  assign cmd.ready = s1_en;

  // pipeline valids and command register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_en) s1_valid <= cmd.valid;
      if (s2_en) s2_valid <= s1_valid;
      if (out_en) out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && cmd.valid) begin
      s1_op   <= ptc_pkg::op_t'(cmd.op);
      s1_now  <= ptc_pkg::clamp_input(cmd.now_ms);
      s1_wall <= ptc_pkg::clamp_input(cmd.wall_ms);
      s1_arg  <= cmd.arg_ms;
    end
    if (s2_en && s1_valid) begin
      s2_now <= s1_now;
    end
  end

  assign is_done    = (mode == ptc_pkg::MODE_EXPIRED) || (mode == ptc_pkg::MODE_MISSED);
  assign has_expiry = is_done || (mode == ptc_pkg::MODE_RUNNING);

  assign run_remaining  = ptc_pkg::sat_sub(stored_remaining,
                            ptc_pkg::clamp_zero(ptc_pkg::sat_sub(s1_now, start_mono)));
  assign boot_remaining = ptc_pkg::sat_sub(stored_remaining,
                            ptc_pkg::clamp_zero(ptc_pkg::sat_sub(s1_wall, start_wall)));
  assign set_delta      = ptc_pkg::sat_sub(s1_now, start_mono);
  assign tset_remaining = ptc_pkg::sat_sub(stored_remaining, set_delta);

  assign new_remaining = (s1_op != ptc_pkg::OP_ADD_MINUTE) ? s1_arg :
                         is_done ? ptc_pkg::ONE_MINUTE :
                         ptc_pkg::sat_add(stored_remaining, ptc_pkg::ONE_MINUTE);
  assign new_total  = ptc_pkg::sat_add(total_length,
                        ptc_pkg::sat_sub(new_remaining, stored_remaining));
  assign rem_change = (new_remaining != stored_remaining) && (mode != ptc_pkg::MODE_RESET);
  assign arg_above_min = s1_arg > $signed({1'b0, len_floor});

  // apply one command to the record
  always_comb begin
    mode_next             = mode;
    set_length_next       = set_length;
    total_length_next     = total_length;
    stored_remaining_next = stored_remaining;
    start_mono_next       = start_mono;
    start_wall_next       = start_wall;
    unique case (s1_op)
      ptc_pkg::OP_START: begin
        if (mode == ptc_pkg::MODE_PAUSED || mode == ptc_pkg::MODE_RESET) begin
          mode_next       = ptc_pkg::MODE_RUNNING;
          start_mono_next = s1_now;
          start_wall_next = s1_wall;
        end
      end
      ptc_pkg::OP_PAUSE, ptc_pkg::OP_RESET: begin
        if ((s1_op == ptc_pkg::OP_PAUSE && is_done) ||
            (s1_op == ptc_pkg::OP_RESET && mode != ptc_pkg::MODE_RESET)) begin
          mode_next             = ptc_pkg::MODE_RESET;
          total_length_next     = set_length;
          stored_remaining_next = set_length;
          start_mono_next       = '0;
          start_wall_next       = '0;
        end else if (s1_op == ptc_pkg::OP_PAUSE && mode == ptc_pkg::MODE_RUNNING) begin
          mode_next             = ptc_pkg::MODE_PAUSED;
          stored_remaining_next = run_remaining;
          start_mono_next       = '0;
          start_wall_next       = '0;
        end
      end
      ptc_pkg::OP_EXPIRE, ptc_pkg::OP_MISS: begin
        if ((s1_op == ptc_pkg::OP_EXPIRE &&
             (mode == ptc_pkg::MODE_RUNNING || mode == ptc_pkg::MODE_PAUSED)) ||
            (s1_op == ptc_pkg::OP_MISS &&
             mode != ptc_pkg::MODE_RESET && mode != ptc_pkg::MODE_MISSED)) begin
          mode_next = (s1_op == ptc_pkg::OP_EXPIRE) ? ptc_pkg::MODE_EXPIRED
                                                    : ptc_pkg::MODE_MISSED;
          if (!stored_remaining[ptc_pkg::TIME_BITS-1]) stored_remaining_next = '0;
          total_length_next = '0;
          start_mono_next   = s1_now;
          start_wall_next   = s1_wall;
        end
      end
      ptc_pkg::OP_REBOOT: begin
        if (has_expiry) begin
          stored_remaining_next = boot_remaining;
          start_mono_next       = s1_now;
          start_wall_next       = s1_wall;
        end
      end
      ptc_pkg::OP_TIME_SET: begin
        if (has_expiry && !set_delta[ptc_pkg::TIME_BITS-1]) begin
          stored_remaining_next = tset_remaining;
          start_mono_next       = s1_now;
          start_wall_next       = s1_wall;
        end
      end
      ptc_pkg::OP_SET_LENGTH: begin
        if (s1_arg != set_length && arg_above_min) begin
          if (mode == ptc_pkg::MODE_RESET) begin
            total_length_next     = s1_arg;
            stored_remaining_next = s1_arg;
          end
          set_length_next = s1_arg;
        end
      end
      ptc_pkg::OP_SET_REMAIN, ptc_pkg::OP_ADD_MINUTE: begin
        if (rem_change) begin
          total_length_next     = new_total;
          stored_remaining_next = new_remaining;
          if (is_done && !new_remaining[ptc_pkg::TIME_BITS-1] && new_remaining != '0) begin
            mode_next       = ptc_pkg::MODE_RUNNING;
            start_mono_next = s1_now;
            start_wall_next = s1_wall;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign load_len = ptc_pkg::time_t'({1'b0, cfg_wdata});

  // record and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= ptc_pkg::MODE_RESET;
      set_length       <= ptc_pkg::time_t'({1'b0, ptc_pkg::RESET_LENGTH});
      total_length     <= ptc_pkg::time_t'({1'b0, ptc_pkg::RESET_LENGTH});
      stored_remaining <= ptc_pkg::time_t'({1'b0, ptc_pkg::RESET_LENGTH});
      start_mono       <= '0;
      start_wall       <= '0;
      len_floor        <= '0;
    end else if (cfg_wr_en) begin
      unique case (ptc_pkg::cfg_index_t'(cfg_index))
        ptc_pkg::CFG_INITIAL_LENGTH: begin
          mode             <= ptc_pkg::MODE_RESET;
          set_length       <= load_len;
          total_length     <= load_len;
          stored_remaining <= load_len;
          start_mono       <= '0;
          start_wall       <= '0;
        end
        ptc_pkg::CFG_MIN_LENGTH: begin
          len_floor <= cfg_wdata;
        end
      endcase
    end else if (s1_valid && s2_en) begin
      mode             <= mode_next;
      set_length       <= set_length_next;
      total_length     <= total_length_next;
      stored_remaining <= stored_remaining_next;
      start_mono       <= start_mono_next;
      start_wall       <= start_wall_next;
    end
  end

  // status from the updated record
  assign now_remaining = (mode == ptc_pkg::MODE_PAUSED || mode == ptc_pkg::MODE_RESET) ?
                         stored_remaining :
                         ptc_pkg::sat_sub(stored_remaining,
                           ptc_pkg::clamp_zero(ptc_pkg::sat_sub(s2_now, start_mono)));

  always_ff @(posedge clk) begin
    if (out_en && s2_valid) begin
      out_state        <= mode;
      out_remaining    <= now_remaining;
      out_total        <= total_length;
      out_expiry_valid <= has_expiry;
      out_expiry       <= has_expiry ? ptc_pkg::sat_add(start_mono, stored_remaining) : '0;
      out_wall_expiry  <= has_expiry ? ptc_pkg::sat_add(start_wall, stored_remaining) : '0;
    end
  end

  assign status.valid             = out_valid;
  assign status.timer_state       = out_state;
  assign status.remaining_ms      = out_remaining;
  assign status.total_ms          = out_total;
  assign status.expiry_valid      = out_expiry_valid;
  assign status.expiry_at_ms      = out_expiry;
  assign status.wall_expiry_at_ms = out_wall_expiry;

endmodule

// ===== design/ptc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pausable countdown timer checker
// Port-level checks on the status channel and command ready, bound to the core.
// ----------------------------------------------------------------------------
module ptc_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input logic [2:0]     out_state,
  input logic           out_expiry_valid,
  input ptc_pkg::time_t out_expiry,
  input ptc_pkg::time_t out_wall_expiry
);

  // drop status after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("status valid after reset");

  a_expiry_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_expiry_valid ==
      (out_state == ptc_pkg::MODE_RUNNING || out_state == ptc_pkg::MODE_EXPIRED ||
       out_state == ptc_pkg::MODE_MISSED)))
    else $error("expiry flag does not match state");

  a_expiry_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_expiry_valid) |-> (out_expiry == '0 && out_wall_expiry == '0))
    else $error("expiry times set without expiry");

  // an empty status register never blocks commands
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("command blocked while status empty");

  a_status_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_state)))
    else $error("stalled status changed");

endmodule

bind pausable_countdown_timer_core ptc_checker u_ptc_checker (
  .clk              (clk),
  .rst              (rst),
  .in_ready         (cmd.ready),
  .out_valid        (status.valid),
  .out_ready        (status.ready),
  .out_state        (status.timer_state),
  .out_expiry_valid (status.expiry_valid),
  .out_expiry       (status.expiry_at_ms),
  .out_wall_expiry  (status.wall_expiry_at_ms)
);
